// File: hw/rtl/rfc_pkg.sv
`default_nettype none

package rfc_pkg;

   // Field widths of the checker
   localparam int COUNT_BITS     = 16;
   localparam int BULK_LEN_BITS  = 24;
   localparam int FRAME_LEN_BITS = 32;
   localparam int NUM_BITS       = (COUNT_BITS > BULK_LEN_BITS) ? COUNT_BITS : BULK_LEN_BITS;
   localparam int ACC_BITS       = NUM_BITS + 4;

   localparam logic [ACC_BITS-1:0] COUNT_LIMIT = ACC_BITS'((64'd1 << COUNT_BITS) - 64'd1);
   localparam logic [ACC_BITS-1:0] BULK_LIMIT  = ACC_BITS'((64'd1 << BULK_LEN_BITS) - 64'd1);

   // Result status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_ERROR = 2'd1;
   localparam logic [1:0] ST_HALF  = 2'd2;

   // Parser phases
   localparam logic [3:0] PH_STAR        = 4'd0;
   localparam logic [3:0] PH_CNT_LEAD    = 4'd1;
   localparam logic [3:0] PH_CNT_BODY    = 4'd2;
   localparam logic [3:0] PH_CNT_LEAD_CR = 4'd3;
   localparam logic [3:0] PH_CNT_BODY_CR = 4'd4;
   localparam logic [3:0] PH_DOLLAR      = 4'd5;
   localparam logic [3:0] PH_BLK_LEAD    = 4'd6;
   localparam logic [3:0] PH_BLK_BODY    = 4'd7;
   localparam logic [3:0] PH_BLK_LEAD_CR = 4'd8;
   localparam logic [3:0] PH_BLK_BODY_CR = 4'd9;
   localparam logic [3:0] PH_PAYLOAD     = 4'd10;

   // Characters
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_FF     = 8'h0C;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] frame_length;
      logic [23:0] max_bulk_length;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/resp_frame_checker.sv
//  channel | ports                          | payload
//  --------+--------------------------------+------------------------------------------
//  request | req_valid, req_ready, req_data | data_byte, end_of_buffer (one byte)
//  result  | rsp_valid, rsp_ready, rsp_data | status, frame_length, max_bulk_length
//
//  One byte per cycle while results are taken; a staged byte's result goes to the result register.
//  The byte stage register feeds the parser step, which writes the result register.
//  reset (synchronous, active high) returns the parser to waiting for '*'.
//  A pending result that is not taken stalls the byte stage only; bytes keep
//  flowing while the result register is empty or being drained.
`default_nettype none

module resp_frame_checker
   import rfc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   // byte stage
   logic    stg_valid_ff, stg_valid_in;
   req_type stg_data_ff;

   // parser state
   logic [3:0]                phase_ff, phase_in;
   logic [NUM_BITS-1:0]       acc_ff, acc_in;
   logic                      neg_ff, neg_in;
   logic                      ended_ff, ended_in;
   logic [COUNT_BITS-1:0]     elem_ff, elem_in;
   logic [BULK_LEN_BITS:0]    pay_ff, pay_in;
   logic [FRAME_LEN_BITS-1:0] bytes_ff, bytes_in;
   logic [BULK_LEN_BITS-1:0]  big_ff, big_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // step signals
   logic                      advance;
   logic                      res_valid;
   logic [1:0]                res_status;
   logic [7:0]                b;
   logic                      eob;
   logic [FRAME_LEN_BITS-1:0] bytes_inc;
   logic                      num_step;
   logic [3:0]                num_ph;
   logic                      num_ended;
   logic                      is_lead;
   logic                      is_bulk;
   logic                      is_digit;
   logic                      is_space;
   logic [ACC_BITS-1:0]       acc_next;
   logic [ACC_BITS-1:0]       limit;

   // stage moves when there is room for a possible result
   assign advance   = stg_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stg_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign b         = stg_data_ff.data_byte;
   assign eob       = stg_data_ff.end_of_buffer;
   assign bytes_inc = bytes_ff + FRAME_LEN_BITS'(1);
   assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
   assign is_space  = (b == CH_SPACE) || (b == CH_CR) || ((b >= CH_TAB) && (b <= CH_FF));
   assign acc_next  = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                      + ACC_BITS'(b[3:0]);

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      neg_in     = neg_ff;
      ended_in   = ended_ff;
      elem_in    = elem_ff;
      pay_in     = pay_ff;
      bytes_in   = bytes_inc;
      big_in     = big_ff;
      res_valid  = 1'b0;
      res_status = ST_HALF;
      num_step   = 1'b0;
      num_ph     = phase_ff;
      num_ended  = ended_ff;
      is_lead    = 1'b0;
      is_bulk    = (phase_ff >= PH_BLK_LEAD);
      limit      = is_bulk ? BULK_LIMIT : COUNT_LIMIT;

      if (&bytes_ff) begin
         // frame would exceed the length counter
         res_valid  = 1'b1;
         res_status = ST_ERROR;
      end else begin
         unique case (phase_ff)
            PH_CNT_LEAD, PH_CNT_BODY, PH_BLK_LEAD, PH_BLK_BODY: begin
               num_step = 1'b1;
            end
            PH_CNT_LEAD_CR, PH_CNT_BODY_CR, PH_BLK_LEAD_CR, PH_BLK_BODY_CR: begin
               if (b == CH_LF) begin
                  if (!is_bulk) begin
                     if (neg_ff || acc_ff == '0) begin
                        res_valid  = 1'b1;
                        res_status = ST_DONE;
                     end else begin
                        elem_in  = COUNT_BITS'(acc_ff);
                        phase_in = PH_DOLLAR;
                     end
                  end else if (neg_ff && acc_ff != '0) begin
                     res_valid  = 1'b1;
                     res_status = ST_ERROR;
                  end else begin
                     if (BULK_LEN_BITS'(acc_ff) > big_ff) big_in = BULK_LEN_BITS'(acc_ff);
                     pay_in   = (BULK_LEN_BITS + 1)'(acc_ff) + (BULK_LEN_BITS + 1)'(2);
                     phase_in = PH_PAYLOAD;
                  end
                  acc_in   = '0;
                  neg_in   = 1'b0;
                  ended_in = 1'b0;
               end else begin
                  // held CR was a plain field byte
                  num_step  = 1'b1;
                  num_ph    = phase_ff - 4'd2;
                  num_ended = ended_ff || (phase_ff == PH_CNT_BODY_CR)
                              || (phase_ff == PH_BLK_BODY_CR);
               end
            end
            PH_DOLLAR: begin
               if (b != CH_DOLLAR) begin
                  res_valid  = 1'b1;
                  res_status = ST_ERROR;
               end
               acc_in   = '0;
               neg_in   = 1'b0;
               ended_in = 1'b0;
               phase_in = PH_BLK_LEAD;
            end
            PH_PAYLOAD: begin
               if (pay_ff <= (BULK_LEN_BITS + 1)'(1)) begin
                  pay_in = '0;
                  if (elem_ff <= COUNT_BITS'(1)) begin
                     elem_in    = '0;
                     res_valid  = 1'b1;
                     res_status = ST_DONE;
                  end else begin
                     elem_in  = elem_ff - COUNT_BITS'(1);
                     phase_in = PH_DOLLAR;
                  end
               end else begin
                  pay_in = pay_ff - (BULK_LEN_BITS + 1)'(1);
               end
            end
            default: begin
               if (b != CH_STAR) begin
                  res_valid  = 1'b1;
                  res_status = ST_ERROR;
               end
               acc_in   = '0;
               neg_in   = 1'b0;
               ended_in = 1'b0;
               phase_in = PH_CNT_LEAD;
            end
         endcase

         // one byte of a decimal field
         is_lead = (num_ph == PH_CNT_LEAD) || (num_ph == PH_BLK_LEAD);
         if (num_step) begin
            phase_in = num_ph;
            ended_in = num_ended;
            if (b == CH_CR) begin
               phase_in = num_ph + 4'd2;
            end else if (is_lead && is_space) begin
               phase_in = num_ph;
            end else if (is_lead && (b == CH_PLUS || b == CH_MINUS)) begin
               phase_in = num_ph + 4'd1;
               neg_in   = (b == CH_MINUS);
            end else if (!is_lead && num_ended) begin
               phase_in = num_ph;
            end else if (!is_digit) begin
               if (is_lead) phase_in = num_ph + 4'd1;
               ended_in = 1'b1;
            end else begin
               if (is_lead) phase_in = num_ph + 4'd1;
               if (acc_next > limit) begin
                  res_valid  = 1'b1;
                  res_status = ST_ERROR;
               end else begin
                  acc_in = NUM_BITS'(acc_next);
               end
            end
         end

         if (eob && !res_valid) begin
            res_valid  = 1'b1;
            res_status = ST_HALF;
         end
      end

      rsp_in.status          = res_status;
      rsp_in.frame_length    = (res_status == ST_DONE) ? 32'(bytes_inc) : 32'd0;
      // includes a length declared by this very byte
      rsp_in.max_bulk_length = 24'(big_in);
   end

   assign stg_valid_in = req_ready ? req_valid : stg_valid_ff;
   assign rsp_valid_in = advance ? res_valid : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (req_ready) stg_data_ff <= req_data;
      if (advance && res_valid) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_STAR;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         ended_ff     <= 1'b0;
         elem_ff      <= '0;
         pay_ff       <= '0;
         bytes_ff     <= '0;
         big_ff       <= '0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            if (res_valid) begin
               // every result restarts the frame
               phase_ff <= PH_STAR;
               acc_ff   <= '0;
               neg_ff   <= 1'b0;
               ended_ff <= 1'b0;
               elem_ff  <= '0;
               pay_ff   <= '0;
               bytes_ff <= '0;
               big_ff   <= '0;
            end else begin
               phase_ff <= phase_in;
               acc_ff   <= acc_in;
               neg_ff   <= neg_in;
               ended_ff <= ended_in;
               elem_ff  <= elem_in;
               pay_ff   <= pay_in;
               bytes_ff <= bytes_in;
               big_ff   <= big_in;
            end
         end
      end
   end

   // a frame length is reported only for a completed frame
   a_len_done_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != ST_DONE) |-> rsp_ff.frame_length == 32'd0)
      else $error("frame length on a non-complete result");

   // a result restarts the parser
   a_restart: assert property (@(posedge clock) disable iff (reset)
      advance && res_valid |=> phase_ff == PH_STAR && bytes_ff == '0)
      else $error("parser not restarted after result");

   // a held result keeps the byte stage from moving
   a_stall: assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff && rsp_valid_ff && !rsp_ready |=> stg_valid_ff && $stable(phase_ff))
      else $error("byte stage moved while result stalled");

   // payload phase always has bytes left to count
   a_payload: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> pay_ff != '0)
      else $error("payload phase with nothing left");

endmodule

`default_nettype wire

// File: dv/tb_resp_frame_checker.sv
`timescale 1ns / 100ps

module tb_resp_frame_checker;
   import rfc_pkg::*;

   // Magnitude limits of the number fields and of a whole frame
   localparam longint unsigned COUNT_CAP = (64'd1 << COUNT_BITS) - 64'd1;
   localparam longint unsigned BULK_CAP  = (64'd1 << BULK_LEN_BITS) - 64'd1;
   localparam longint unsigned FRAME_CAP = (64'd1 << FRAME_LEN_BITS) - 64'd1;

   // Vertical tab is a blank for the number reader but has no package constant
   localparam logic [7:0] CH_VT = 8'h0B;

   localparam int HOLD_CYCLES = 300;   // long receiver hold-off
   localparam int BASE_IDLE   = 36;    // percent of cycles each side idles
   localparam int SETTLE      = 10;    // cycles past the last result
   localparam int TIMEOUT_NS  = 1_000_000;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Verdicts the parser owes us, oldest first
   rsp_type    verdict_q[$];
   logic [7:0] frame_text[$];   // bytes staged for the next burst

   int idle_pct       = BASE_IDLE;
   int bytes_sent     = 0;
   int mismatch_count = 0;
   int hold_requests  = 0;
   int holds_served   = 0;

   // Parser state mirrored by the predictor
   logic [3:0]      cur_phase   = PH_STAR;
   longint unsigned num_value   = 0;
   bit              num_minus   = 1'b0;
   bit              num_done    = 1'b0;
   longint unsigned elems_left  = 0;
   longint unsigned data_left   = 0;
   longint unsigned frame_bytes = 0;
   longint unsigned widest_bulk = 0;

   resp_frame_checker DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Frame predictor
   // ------------------------------------------------------------------

   function automatic void clear_number();
      num_value = 0;
      num_minus = 1'b0;
      num_done  = 1'b0;
   endfunction

   // Builds the verdict and drops back to waiting for '*'
   function automatic bit close_frame(input logic [1:0] code, output rsp_type verdict);
      verdict.status          = code;
      verdict.frame_length    = (code == ST_DONE) ? 32'(frame_bytes) : 32'd0;
      verdict.max_bulk_length = 24'(widest_bulk);
      cur_phase   = PH_STAR;
      elems_left  = 0;
      data_left   = 0;
      frame_bytes = 0;
      widest_bulk = 0;
      clear_number();
      return 1'b1;
   endfunction

   // One byte of a decimal field, strtol style. Returns 0 on overflow.
   function automatic bit take_number_char(input logic [7:0] b, input longint unsigned limit);
      bit              lead_phase;
      bit              is_digit;
      longint unsigned grown;
      lead_phase = (cur_phase == PH_CNT_LEAD) || (cur_phase == PH_BLK_LEAD);
      is_digit   = (b >= CH_ZERO) && (b <= CH_NINE);
      if (lead_phase) begin
         if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT ||
             b == CH_FF || b == CH_CR)
            return 1'b1;
         cur_phase = cur_phase + 4'd1;   // lead -> body
         if (b == CH_PLUS || b == CH_MINUS) begin
            num_minus = (b == CH_MINUS);
            return 1'b1;
         end
         if (!is_digit) begin
            num_done = 1'b1;
            return 1'b1;
         end
      end else if (num_done) begin
         return 1'b1;
      end else if (!is_digit) begin
         num_done = 1'b1;
         return 1'b1;
      end
      grown = num_value * 10 + longint'(b - CH_ZERO);
      if (grown > limit)
         return 1'b0;
      num_value = grown;
      return 1'b1;
   endfunction

   // Advances the mirrored parser by one byte; returns 1 when a verdict is due
   function automatic bit parse_resp_byte(input req_type item, output rsp_type verdict);
      logic [7:0] b;
      bit         bulk;
      b = item.data_byte;
      frame_bytes++;
      if (frame_bytes > FRAME_CAP)
         return close_frame(ST_ERROR, verdict);

      case (cur_phase)
         PH_CNT_LEAD, PH_CNT_BODY, PH_BLK_LEAD, PH_BLK_BODY: begin
            bulk = (cur_phase >= PH_BLK_LEAD);
            if (b == CH_CR)
               cur_phase = cur_phase + 4'd2;
            else if (!take_number_char(b, bulk ? BULK_CAP : COUNT_CAP))
               return close_frame(ST_ERROR, verdict);
         end
         PH_CNT_LEAD_CR, PH_CNT_BODY_CR, PH_BLK_LEAD_CR, PH_BLK_BODY_CR: begin
            bulk = (cur_phase >= PH_BLK_LEAD);
            if (b == CH_LF) begin
               if (!bulk) begin
                  // negative or zero count closes the frame right here
                  if (num_minus || num_value == 0)
                     return close_frame(ST_DONE, verdict);
                  elems_left = num_value;
                  cur_phase  = PH_DOLLAR;
               end else begin
                  // "-0" is allowed, any other negative length is not
                  if (num_minus && num_value != 0)
                     return close_frame(ST_ERROR, verdict);
                  if (num_value > widest_bulk)
                     widest_bulk = num_value;
                  data_left = num_value + 2;   // payload plus unchecked trailer
                  cur_phase = PH_PAYLOAD;
               end
               clear_number();
            end else begin
               // CR without LF was just an ordinary byte of the field
               if (cur_phase == PH_CNT_BODY_CR || cur_phase == PH_BLK_BODY_CR)
                  num_done = 1'b1;
               cur_phase = cur_phase - 4'd2;
               if (b == CH_CR)
                  cur_phase = cur_phase + 4'd2;
               else if (!take_number_char(b, bulk ? BULK_CAP : COUNT_CAP))
                  return close_frame(ST_ERROR, verdict);
            end
         end
         PH_DOLLAR: begin
            if (b != CH_DOLLAR)
               return close_frame(ST_ERROR, verdict);
            clear_number();
            cur_phase = PH_BLK_LEAD;
         end
         PH_PAYLOAD: begin
            if (data_left > 0)
               data_left--;
            if (data_left == 0) begin
               if (elems_left > 0)
                  elems_left--;
               if (elems_left == 0)
                  return close_frame(ST_DONE, verdict);
               cur_phase = PH_DOLLAR;
            end
         end
         default: begin
            if (b != CH_STAR)
               return close_frame(ST_ERROR, verdict);
            clear_number();
            cur_phase = PH_CNT_LEAD;
         end
      endcase

      // a byte that already produced a verdict never gets here
      if (item.end_of_buffer)
         return close_frame(ST_HALF, verdict);
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offers one byte, waits for the transaction, then books its verdict.
   // Valid stays high back to back unless a random idle cycle is drawn.
   task automatic send_byte(input logic [7:0] value, input bit last);
      req_type item;
      rsp_type verdict;
      item.data_byte     = value;
      item.end_of_buffer = last;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (parse_resp_byte(item, verdict))
         verdict_q.push_back(verdict);
      bytes_sent++;
   endtask

   // Drops valid and waits until every booked verdict has come back
   task automatic wait_for_verdicts();
      req_valid <= 1'b0;
      do @(posedge clock); while (verdict_q.size() != 0);
   endtask

   // Sends the staged bytes. A non-negative eob_at cuts the burst there
   // and marks that byte as the end of the buffer.
   task automatic ship_text(input int eob_at);
      int last;
      last = (eob_at < 0) ? frame_text.size() - 1 : eob_at;
      for (int i = 0; i <= last; i++)
         send_byte(frame_text[i], i == eob_at);
      frame_text.delete();
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++)
         frame_text.push_back(s[i]);
   endtask

   // Bytes that steer the parser somewhere interesting more often than chance
   function automatic logic [7:0] pick_noise_byte();
      case ($urandom_range(7))
         0:       return CH_STAR;
         1:       return CH_DOLLAR;
         2:       return CH_CR;
         3:       return CH_LF;
         4:       return CH_ZERO + 8'($urandom_range(9));
         5:       return $urandom_range(1) ? CH_MINUS : CH_PLUS;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Decimal field with CR LF, sometimes dressed up the way strtol tolerates:
   // leading blanks, explicit '+', a leading zero, ignored trailing bytes,
   // or a stray CR that is not part of the terminator.
   task automatic put_number(input longint unsigned value, input bit minus);
      if ($urandom_range(4) == 0) begin
         repeat ($urandom_range(1, 2)) begin
            case ($urandom_range(4))
               0:       frame_text.push_back(CH_SPACE);
               1:       frame_text.push_back(CH_TAB);
               2:       frame_text.push_back(CH_LF);
               3:       frame_text.push_back(CH_VT);
               default: frame_text.push_back(CH_FF);
            endcase
         end
      end
      if (minus)
         frame_text.push_back(CH_MINUS);
      else if ($urandom_range(9) == 0)
         frame_text.push_back(CH_PLUS);
      if ($urandom_range(9) == 0)
         frame_text.push_back(CH_ZERO);
      put_text($sformatf("%0d", value));
      case ($urandom_range(19))
         0, 1: begin   // digit after a blank is ignored
            frame_text.push_back(CH_SPACE);
            frame_text.push_back(CH_ZERO + 8'($urandom_range(9)));
         end
         2: begin      // lone CR ends the number, the digit after it is ignored
            frame_text.push_back(CH_CR);
            frame_text.push_back(CH_ZERO + 8'($urandom_range(9)));
         end
         default: ;
      endcase
      frame_text.push_back(CH_CR);
      frame_text.push_back(CH_LF);
   endtask

   // Well-formed array of bulk strings with random payload and trailer bytes
   task automatic put_frame(input int elems, input int max_len);
      int len;
      put_text("*");
      put_number(elems, 1'b0);
      repeat (elems) begin
         len = $urandom_range(max_len);
         put_text("$");
         put_number(len, 1'b0);
         repeat (len + 2)
            frame_text.push_back(8'($urandom_range(255)));
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   task automatic test_missing_markers();
      put_text("X");           // first byte is not '*'
      ship_text(-1);
      put_text("*1\r\nQ");     // element does not open with '$'
      ship_text(-1);
   endtask

   task automatic test_short_counts();
      put_text("*\r\n");       // no digits reads as a zero count
      ship_text(-1);
      put_text("*-5\r\n");     // negative count completes at once
      ship_text(-1);
   endtask

   task automatic test_bulk_signs();
      // "-0" is a valid empty string, "-1" is rejected at its LF
      put_text("*2\r\n$-0\r\n\r\n$-1\r\n");
      ship_text(-1);
   endtask

   task automatic test_count_overflow();
      put_text("*65536");      // last digit pushes the count past 16 bits
      ship_text(-1);
   endtask

   task automatic test_half_package();
      put_text("*");
      ship_text(0);
   endtask

   // Mostly well-formed frames, plus huge declared lengths, fields at the
   // overflow boundary and short bursts of noise.
   task automatic test_random_frames(input int byte_budget);
      int stop_at;
      int kind;
      int eob_at;
      longint unsigned limit;
      stop_at = bytes_sent + byte_budget;
      while (bytes_sent < stop_at) begin
         kind = $urandom_range(99);
         // leftovers from corrupted frames: one byte with end of buffer clears them
         if (kind < 80 && cur_phase != PH_STAR) begin
            frame_text.push_back(pick_noise_byte());
            ship_text(0);
         end
         if (kind < 60) begin
            put_frame(($urandom_range(19) == 0) ? 0 : $urandom_range(1, 4),
                      ($urandom_range(9) == 0) ? 40 : 6);
            case ($urandom_range(9))
               0, 1:    eob_at = $urandom_range(frame_text.size() - 1);  // truncated
               2, 3:    eob_at = frame_text.size() - 1;  // completes on the marked byte
               4: begin
                  frame_text[$urandom_range(frame_text.size() - 1)] = pick_noise_byte();
                  eob_at = -1;
               end
               default: eob_at = -1;
            endcase
            ship_text(eob_at);
         end else if (kind < 70) begin
            // length far too big to send: buffer runs dry inside the payload,
            // which still reports the declared length
            put_text("*");
            put_number($urandom_range(1, 3), 1'b0);
            put_text("$");
            put_number($urandom_range(1) ? longint'($urandom_range(24'hFFFFFF)) : BULK_CAP,
                       1'b0);
            repeat ($urandom_range(3))
               frame_text.push_back(8'($urandom_range(255)));
            ship_text(frame_text.size() - 1);
         end else if (kind < 80) begin
            // one below, at and one above the field limit
            limit = $urandom_range(1) ? COUNT_CAP : BULK_CAP;
            if (limit == COUNT_CAP)
               put_text("*");
            else
               put_text("*1\r\n$");
            put_text($sformatf("%0d\r\n", limit - 1 + $urandom_range(2)));
            ship_text(frame_text.size() - 1);
         end else begin
            repeat ($urandom_range(1, 6))
               frame_text.push_back(pick_noise_byte());
            ship_text(($urandom_range(3) != 0) ? frame_text.size() - 1 : -1);
         end
      end
   endtask

   // Neither side idles: back-to-back bytes and results
   task automatic test_full_rate();
      idle_pct = 0;
      test_random_frames(350);
      idle_pct = BASE_IDLE;
   endtask

   // Receiver holds off while bytes that each cause an error keep coming,
   // so the result register fills and the byte stage stalls.
   task automatic test_result_stall();
      // start from an idle parser so that no byte below is swallowed by a frame
      if (cur_phase != PH_STAR) begin
         frame_text.push_back(pick_noise_byte());
         ship_text(0);
      end
      hold_requests++;
      idle_pct = 0;
      // never '*', so each byte is a missing-marker error
      repeat (40)
         frame_text.push_back(8'($urandom_range(8'h2B, 8'hFF)));
      ship_text(-1);
      idle_pct = BASE_IDLE;
   endtask

   // Sender goes quiet mid-stream until every verdict is back
   task automatic test_sender_pause();
      test_random_frames(300);
      wait_for_verdicts();
      test_random_frames(300);
   endtask

   // ------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------

   // Random ready, with an occasional long hold-off counted here
   initial begin
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_served++;
         end
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Every result transaction is matched against the oldest booked verdict
   always @(posedge clock) begin : check_verdicts
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) begin
            $error("status: expected no result, got %0d", rsp_data.status);
            mismatch_count++;
         end else begin
            want = verdict_q.pop_front();
            check_field("status", want.status, rsp_data.status);
            check_field("frame_length", want.frame_length, rsp_data.frame_length);
            check_field("max_bulk_length", want.max_bulk_length, rsp_data.max_bulk_length);
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_missing_markers();
      test_short_counts();
      test_bulk_signs();
      test_count_overflow();
      test_half_package();
      test_random_frames(800);
      test_full_rate();
      test_result_stall();
      test_sender_pause();

      // all verdicts back, then wait out SETTLE to catch stray results
      wait_for_verdicts();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0)
         $display("resp_frame_checker: match");
      else
         $display("resp_frame_checker: mismatch");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("resp_frame_checker: mismatch");
      $finish;
   end

endmodule
